/* rtl/core/lru_pkg.sv */
// shared types and constants for the lru age-counter replacement block
// depends on nothing; used by lru_age_replacement

package lru_pkg;

  // cache geometry
  localparam int WAYS   = 8;
  localparam int SETS   = 1024;
  localparam int SLICES = 4;

  // fixed field widths of the transaction payload
  localparam int OP_W    = 1;
  localparam int SLICE_W = 2;
  localparam int SET_W   = 10;
  localparam int WAY_W   = 3;
  localparam int MASK_W  = 8;

  // storage geometry: one memory row holds all ages of one set
  localparam int AGE_W        = $clog2(WAYS);
  localparam int SET_ADDR_W   = $clog2(SETS);
  localparam int SLICE_ADDR_W = $clog2(SLICES);
  localparam int ROW_W        = SLICE_ADDR_W + SET_ADDR_W;
  localparam int ROW_DEPTH    = SLICES * SETS;
  localparam int ROW_BITS     = WAYS * AGE_W;

  // age of the most recently used way
  localparam logic [AGE_W-1:0] AGE_MRU = AGE_W'(WAYS - 1);

  typedef logic [WAYS-1:0][AGE_W-1:0] age_row_t;

  typedef enum logic [OP_W-1:0] {
    LRU_QUERY = 1'b0,
    LRU_TOUCH = 1'b1
  } lru_op_e;

  typedef enum logic [1:0] {
    LRU_CLEAR,
    LRU_IDLE,
    LRU_EXEC
  } lru_state_e;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [SLICE_W-1:0] slice_index;
    logic [SET_W-1:0]   set_index;
    logic [WAY_W-1:0]   way_index;
    logic [MASK_W-1:0]  valid_mask;
  } lru_in_t;

  typedef struct packed {
    logic [WAY_W-1:0] victim_way;
    logic             victim_was_invalid;
  } lru_out_t;

endpackage

/* rtl/core/lru_age_replacement.sv */
// true-lru replacement with per-way age counters, one memory row per set
// an accepted transaction is read from memory into the ram read register, then
// EXEC puts its result in the output register, waiting while a held result fills it
// input stalls until a transaction is done (memory read, then modify and write back)
// the output register lets the next transaction enter while a result waits
// after reset a clearing pass zeroes all ROW_DEPTH rows, input stalled
// depends on lru_pkg and lru_ram

module lru_age_replacement (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  lru_pkg::lru_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lru_pkg::lru_out_t out_data_o
);

  lru_pkg::lru_state_e state_q, state_d;
  logic [lru_pkg::ROW_W-1:0] clr_cnt_q, clr_cnt_d;
  lru_pkg::lru_in_t  item_q;
  logic [lru_pkg::ROW_W-1:0] row_q;
  logic              out_valid_q, out_valid_d;
  lru_pkg::lru_out_t out_data_q, out_data_d;

  logic                         in_accept;
  logic                         out_free;
  logic [lru_pkg::ROW_W-1:0]    in_row;
  logic                         ram_we;
  logic [lru_pkg::ROW_W-1:0]    ram_waddr;
  logic [lru_pkg::ROW_BITS-1:0] ram_wdata;
  logic [lru_pkg::ROW_BITS-1:0] ram_rdata;

  lru_pkg::age_row_t          ages;
  lru_pkg::age_row_t          ages_new;
  logic [lru_pkg::WAYS-1:0]   way_valid;
  logic                       inv_found;
  logic [lru_pkg::WAY_W-1:0]  inv_way;
  logic [lru_pkg::WAY_W-1:0]  zero_way;
  logic [lru_pkg::AGE_W-1:0]  old_age;
  logic                       way_in_range;
  logic                       is_touch;

  // handshake
  assign in_stall_o = (state_q != lru_pkg::LRU_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // row of the incoming set: slice and set reduced to the stored range
  assign in_row = {in_data_i.slice_index[lru_pkg::SLICE_ADDR_W-1:0],
                   in_data_i.set_index[lru_pkg::SET_ADDR_W-1:0]};

  lru_ram #(
    .WIDTH(lru_pkg::ROW_BITS),
    .DEPTH(lru_pkg::ROW_DEPTH)
  ) u_age_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (in_accept),
    .raddr_i(in_row),
    .rdata_o(ram_rdata)
  );

  assign ages     = lru_pkg::age_row_t'(ram_rdata);
  assign is_touch = (item_q.operation == lru_pkg::LRU_TOUCH);

  // mask bits beyond the transported mask read as invalid
  always_comb begin
    for (int i = 0; i < lru_pkg::WAYS; i++) begin
      way_valid[i] = (i < lru_pkg::MASK_W) ? item_q.valid_mask[i % lru_pkg::MASK_W] : 1'b0;
    end
  end

  // lowest invalid way and lowest way of age zero
  always_comb begin
    inv_found = 1'b0;
    inv_way   = '0;
    zero_way  = '0;
    for (int i = lru_pkg::WAYS - 1; i >= 0; i--) begin
      if (!way_valid[i]) begin
        inv_found = 1'b1;
        inv_way   = lru_pkg::WAY_W'(i);
      end
      if (ages[i] == '0) begin
        zero_way = lru_pkg::WAY_W'(i);
      end
    end
  end

  // touch: age the younger ways down and make the touched way most recent
  always_comb begin
    old_age      = '0;
    way_in_range = (int'(item_q.way_index) < lru_pkg::WAYS);
    for (int i = 0; i < lru_pkg::WAYS; i++) begin
      if (int'(item_q.way_index) == i) begin
        old_age = ages[i];
      end
    end
    for (int i = 0; i < lru_pkg::WAYS; i++) begin
      if (int'(item_q.way_index) == i) begin
        ages_new[i] = lru_pkg::AGE_MRU;
      end else if (ages[i] > old_age) begin
        ages_new[i] = ages[i] - lru_pkg::AGE_W'(1);
      end else begin
        ages_new[i] = ages[i];
      end
    end
  end

  // next state, write back and result
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = row_q;
    ram_wdata   = ages_new;
    case (state_q)
      lru_pkg::LRU_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + lru_pkg::ROW_W'(1);
        if (clr_cnt_q == lru_pkg::ROW_W'(lru_pkg::ROW_DEPTH - 1)) begin
          state_d = lru_pkg::LRU_IDLE;
        end
      end
      lru_pkg::LRU_IDLE: begin
        if (in_accept) begin
          state_d = lru_pkg::LRU_EXEC;
        end
      end
      lru_pkg::LRU_EXEC: begin
        if (out_free) begin
          state_d     = lru_pkg::LRU_IDLE;
          out_valid_d = 1'b1;
          if (is_touch) begin
            ram_we                        = way_in_range;
            out_data_d.victim_way         = '0;
            out_data_d.victim_was_invalid = 1'b0;
          end else begin
            out_data_d.victim_way         = inv_found ? inv_way : zero_way;
            out_data_d.victim_was_invalid = inv_found;
          end
        end
      end
      default: begin
        state_d = lru_pkg::LRU_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lru_pkg::LRU_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
      row_q  <= in_row;
    end
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* rtl/core/lru_ram.sv */
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module lru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
